/* rtl/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg: shared definitions for the byte ring buffer
// Command and status codes, payload records and default sizes.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int CAPACITY_DEF  = 4096;
    localparam int MAX_BURST_DEF = 64;

    localparam int SEQ_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int HELD_W    = 13;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED      = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] write_byte;
        logic [LEN_W-1:0]  length;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_byte;
        logic                last;
        logic [SEQ_W-1:0]    seq_first;
        logic [SEQ_W-1:0]    seq_next;
        logic [HELD_W-1:0]   held_count;
    } res_item_t;

endpackage

/* rtl/brb_chan_if.sv */
// ----------------------------------------------------------------------------
// brb_chan_if: valid/ready channel
// Carries one payload record per transaction between a source and a sink.
// ----------------------------------------------------------------------------
interface brb_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/byte_ring_buffer_with_sequence_unit.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_sequence_unit: byte FIFO ring with stream sequence
// A byte ring in one RAM that tracks the sequence numbers of its oldest held
// byte and of the next byte to be written, as a stream send/receive buffer.
// ----------------------------------------------------------------------------
// Each transaction on cmd is a write, read, peek or close. A write, a close,
// and any command that ends in would-block, closed or a zero-length request
// produce one result transaction. A read or peek of n bytes (n is the request
// clipped to MAX_BURST and to the bytes held) produces n result transactions,
// one byte per cycle while the output register is free, and keeps the block
// busy: it first fetches the oldest byte through the RAM's registered read
// port, then hands one byte at a time to the output register while the next
// byte is fetched. A finished result waits in the output register, and a
// new command is taken while that register drains. The RAM needs no clearing
// pass after reset: only held bytes are ever read. Write the sequence base
// (cfg_wdata under cfg_we) only while idle; it sets seq_first to the value and
// seq_next to the value plus the held count, and the held bytes stay. After a
// close every command returns status closed.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_sequence_unit #(
    parameter int CAPACITY  = brb_pkg::CAPACITY_DEF,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [brb_pkg::SEQ_W-1:0]  cfg_wdata,
    brb_chan_if.sink                   cmd,
    brb_chan_if.source                 res
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CMP_W   = (CNT_W > brb_pkg::LEN_W) ? CNT_W : brb_pkg::LEN_W;

    typedef enum logic {
        S_IDLE,
        S_BURST
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]            wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]            ptr_reg, ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [brb_pkg::SEQ_W-1:0]   first_reg, first_next;
    logic [brb_pkg::SEQ_W-1:0]   next_reg, next_next;
    logic [BURST_W-1:0]          rem_reg, rem_next;
    logic                        is_read_reg, is_read_next;
    logic                        closed_reg, closed_next;
    logic                        res_valid_reg, res_valid_next;
    brb_pkg::res_item_t          res_item_reg, res_item_next;

    brb_pkg::cmd_item_t          cmd_item;
    logic                        accept;
    logic                        out_free;
    logic [brb_pkg::LEN_W-1:0]   len_clip;
    logic [BURST_W-1:0]          burst_len;

    logic                        ram_we;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_raddr;
    logic [brb_pkg::BYTE_W-1:0]  ram_rdata;

    // Step a ring index, wrapping at CAPACITY.
    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i);
        adv = (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    // Assemble one result record from the state after its byte is handled.
    function automatic brb_pkg::res_item_t mk_res(
        input logic [brb_pkg::STATUS_W-1:0] status,
        input logic [brb_pkg::BYTE_W-1:0]   data,
        input logic                         last,
        input logic [brb_pkg::SEQ_W-1:0]    first,
        input logic [brb_pkg::SEQ_W-1:0]    next,
        input logic [CNT_W-1:0]             count
    );
        brb_pkg::res_item_t r;
        logic [31:0]        cnt32;
        cnt32        = 32'(count);
        r.status     = status;
        r.data_byte  = data;
        r.last       = last;
        r.seq_first  = first;
        r.seq_next   = next;
        r.held_count = cnt32[brb_pkg::HELD_W-1:0];
        mk_res = r;
    endfunction

    // The byte store: written by write commands, read by read/peek bursts.
    brb_ram #(
        .WIDTH (brb_pkg::BYTE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (cmd_item.write_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_item  = cmd.payload;
    // The output register is free when empty or being drained this cycle.
    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign res.valid   = res_valid_reg;
    assign res.payload = res_item_reg;

    // Burst length: clip the request to MAX_BURST, then to the bytes held.
    assign len_clip  = (cmd_item.length > brb_pkg::LEN_W'(MAX_BURST))
                     ? brb_pkg::LEN_W'(MAX_BURST) : cmd_item.length;
    assign burst_len = (CMP_W'(count_reg) < CMP_W'(len_clip))
                     ? BURST_W'(count_reg) : BURST_W'(len_clip);

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        next_next      = next_reg;
        rem_next       = rem_reg;
        is_read_next   = is_read_reg;
        closed_next    = closed_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_item_next  = res_item_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_idx_reg;

        // Rebase the sequence numbers, keep the held bytes.
        if (cfg_we)
        begin
            first_next = cfg_wdata;
            next_next  = cfg_wdata + brb_pkg::SEQ_W'(count_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (closed_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_item_next  = mk_res(brb_pkg::ST_CLOSED, '0, 1'b1,
                                                first_reg, next_reg, count_reg);
                    end
                    else
                    begin
                        case (cmd_item.command)
                            brb_pkg::CMD_CLOSE:
                            begin
                                closed_next    = 1'b1;
                                res_valid_next = 1'b1;
                                res_item_next  = mk_res(brb_pkg::ST_OK, '0, 1'b1,
                                                        first_reg, next_reg, count_reg);
                            end
                            brb_pkg::CMD_WRITE:
                            begin
                                res_valid_next = 1'b1;
                                if (count_reg >= CNT_W'(CAPACITY))
                                begin
                                    res_item_next = mk_res(brb_pkg::ST_WOULD_BLOCK, '0,
                                                           1'b1, first_reg, next_reg,
                                                           count_reg);
                                end
                                else
                                begin
                                    // Store the byte and advance the write side.
                                    ram_we        = 1'b1;
                                    wr_idx_next   = adv(wr_idx_reg);
                                    next_next     = next_reg + 1'b1;
                                    count_next    = count_reg + 1'b1;
                                    res_item_next = mk_res(brb_pkg::ST_OK, '0, 1'b1,
                                                           first_reg, next_next,
                                                           count_next);
                                end
                            end
                            default:
                            begin
                                // Read or peek.
                                if (count_reg == '0)
                                begin
                                    res_valid_next = 1'b1;
                                    res_item_next  = mk_res(brb_pkg::ST_WOULD_BLOCK, '0,
                                                            1'b1, first_reg, next_reg,
                                                            count_reg);
                                end
                                else if (burst_len == '0)
                                begin
                                    res_valid_next = 1'b1;
                                    res_item_next  = mk_res(brb_pkg::ST_OK, '0, 1'b1,
                                                            first_reg, next_reg,
                                                            count_reg);
                                end
                                else
                                begin
                                    // Fetch the oldest byte; the burst state registers its result.
                                    ram_re       = 1'b1;
                                    ram_raddr    = rd_idx_reg;
                                    ptr_next     = adv(rd_idx_reg);
                                    rem_next     = burst_len;
                                    is_read_next = (cmd_item.command == brb_pkg::CMD_READ);
                                    state_next   = S_BURST;
                                end
                            end
                        endcase
                    end
                end
            end
            S_BURST:
            begin
                // Hand the fetched byte over, fetch the next one behind it.
                if (out_free)
                begin
                    if (is_read_reg)
                    begin
                        rd_idx_next = ptr_reg;
                        first_next  = first_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                    res_valid_next = 1'b1;
                    res_item_next  = mk_res(brb_pkg::ST_OK, ram_rdata,
                                            rem_reg == BURST_W'(1),
                                            first_next, next_reg, count_next);
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == BURST_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg;
                        ptr_next  = adv(ptr_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            next_reg      <= '0;
            rem_reg       <= '0;
            is_read_reg   <= 1'b0;
            closed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            res_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            next_reg      <= next_next;
            rem_reg       <= rem_next;
            is_read_reg   <= is_read_next;
            closed_reg    <= closed_next;
            res_valid_reg <= res_valid_next;
            res_item_reg  <= res_item_next;
        end
    end

    // The held count never passes the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count exceeds capacity");

    // The sequence span always equals the held count.
    a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
        (next_reg - first_reg) == brb_pkg::SEQ_W'(count_reg))
        else $error("sequence span and held count disagree");

    // A burst in progress always has bytes left to deliver.
    a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BURST) |-> (rem_reg != '0))
        else $error("burst active with nothing left");

    // A closed result only appears once the ring is closed.
    a_closed_res: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_item_reg.status == brb_pkg::ST_CLOSED)) |-> closed_reg)
        else $error("closed status while ring is open");

endmodule

/* rtl/brb_ram.sv */
// ----------------------------------------------------------------------------
// brb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for byte_ring_buffer_with_sequence_unit
// Drives write, read, peek and close commands through the cmd channel under
// random gaps and result back-pressure. A local model of the ring and its
// sequence numbers predicts every result transaction, which is checked field
// by field. The run covers empty rings, clipped and zero-length bursts,
// sequence wrap and the closed state, with the sequence base reloaded
// between phases while the ring is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int RING_DEPTH     = brb_pkg::CAPACITY_DEF;
    localparam int BURST          = brb_pkg::MAX_BURST_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BURST_FILL     = 40;
    localparam int PHASE_ITEMS    = 60;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [brb_pkg::SEQ_W-1:0]  cfg_wdata;

    brb_chan_if #(.T(brb_pkg::cmd_item_t)) cmd_if ();
    brb_chan_if #(.T(brb_pkg::res_item_t)) res_if ();

    byte_ring_buffer_with_sequence_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // Commands waiting for the driver; the front one is on the bus while valid.
    brb_pkg::cmd_item_t cmd_backlog[$];
    // Result transactions predicted but not yet seen on res.
    brb_pkg::res_item_t ring_results_q[$];

    // Shadow copy of the ring: storage, indexes, sequence numbers, close mark.
    logic [brb_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
    int                         ring_rd = 0;
    int                         ring_wr = 0;
    logic [brb_pkg::SEQ_W-1:0]  seq_head;
    logic [brb_pkg::SEQ_W-1:0]  seq_tail;
    bit                         ring_closed = 1'b0;

    int fail_count = 0;
    int cmd_gap;
    int res_stall;
    int idle_cycles;
    bit steady;     // when set, both sides run without any idling

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Gap length: mostly back-to-back or short, a few long stretches.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Record one expected result from the current shadow state.
    function automatic void queue_result(logic [brb_pkg::STATUS_W-1:0] st,
                                         logic [brb_pkg::BYTE_W-1:0] data,
                                         logic fin);
        brb_pkg::res_item_t        r;
        logic [brb_pkg::SEQ_W-1:0] diff;
        diff         = seq_tail - seq_head;
        r.status     = st;
        r.data_byte  = data;
        r.last       = fin;
        r.seq_first  = seq_head;
        r.seq_next   = seq_tail;
        r.held_count = diff[brb_pkg::HELD_W-1:0];
        ring_results_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Ring predictor: apply one accepted command to the shadow state and
    // queue every result transaction it causes.
    // ------------------------------------------------------------------------
    function automatic void predict_ring_results(brb_pkg::cmd_item_t c);
        logic [brb_pkg::SEQ_W-1:0]  held;
        logic [brb_pkg::BYTE_W-1:0] b;
        int                         n;
        int                         idx;
        held = seq_tail - seq_head;
        if (ring_closed)
        begin
            // Once closed, every command reports closed and nothing moves.
            queue_result(brb_pkg::ST_CLOSED, '0, 1'b1);
        end
        else if (c.command == brb_pkg::CMD_CLOSE)
        begin
            ring_closed = 1'b1;
            queue_result(brb_pkg::ST_OK, '0, 1'b1);
        end
        else if (c.command == brb_pkg::CMD_WRITE)
        begin
            if (held >= RING_DEPTH)
            begin
                // Full ring: drop the byte.
                queue_result(brb_pkg::ST_WOULD_BLOCK, '0, 1'b1);
            end
            else
            begin
                ring_mem[ring_wr] = c.write_byte;
                ring_wr           = (ring_wr + 1) % RING_DEPTH;
                seq_tail          = seq_tail + 1;
                queue_result(brb_pkg::ST_OK, '0, 1'b1);
            end
        end
        else if (held == 0)
        begin
            // Read or peek on an empty ring.
            queue_result(brb_pkg::ST_WOULD_BLOCK, '0, 1'b1);
        end
        else
        begin
            // Clip the request to the burst limit and to the bytes held.
            n = c.length;
            if (n > BURST)
                n = BURST;
            if (n > held)
                n = held;
            if (n == 0)
            begin
                queue_result(brb_pkg::ST_OK, '0, 1'b1);
            end
            else
            begin
                idx = ring_rd;
                for (int i = 0; i < n; i++)
                begin
                    b   = ring_mem[idx];
                    idx = (idx + 1) % RING_DEPTH;
                    // A read consumes each byte before its result is reported.
                    if (c.command == brb_pkg::CMD_READ)
                    begin
                        ring_rd  = idx;
                        seq_head = seq_head + 1;
                    end
                    queue_result(brb_pkg::ST_OK, b, (i + 1 == n));
                end
            end
        end
    endfunction

    function automatic void queue_command(logic [brb_pkg::CMD_W-1:0] op,
                                          logic [brb_pkg::BYTE_W-1:0] data,
                                          int len);
        brb_pkg::cmd_item_t c;
        c.command    = op;
        c.write_byte = data;
        c.length     = brb_pkg::LEN_W'(len);
        cmd_backlog.push_back(c);
    endfunction

    // Random command with the given mix; read takes what is left over.
    function automatic brb_pkg::cmd_item_t random_command(int write_pct, int peek_pct);
        brb_pkg::cmd_item_t c;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < write_pct)
            c.command = brb_pkg::CMD_WRITE;
        else if (r < write_pct + peek_pct)
            c.command = brb_pkg::CMD_PEEK;
        else
            c.command = brb_pkg::CMD_READ;
        c.write_byte = brb_pkg::BYTE_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 6)
            c.length = '0;
        else if (r < 16)
            c.length = brb_pkg::LEN_W'($urandom_range(BURST + 1, 127));
        else if (r < 60)
            c.length = brb_pkg::LEN_W'($urandom_range(1, 8));
        else
            c.length = brb_pkg::LEN_W'($urandom_range(1, BURST));
        return c;
    endfunction

    // Wait until every command is taken and every result has come back,
    // then let the ring sit idle before returning.
    task automatic settle_ring();
        while (cmd_backlog.size() != 0 || ring_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reload the sequence base while idle; the held bytes stay.
    task automatic load_seq_base(input logic [brb_pkg::SEQ_W-1:0] value);
        logic [brb_pkg::SEQ_W-1:0] held;
        settle_ring();
        held = seq_tail - seq_head;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seq_head = value;
        seq_tail = value + held;
    endtask

    function automatic void check_field(string name, logic [brb_pkg::SEQ_W-1:0] want,
                                        logic [brb_pkg::SEQ_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: present the front of the backlog, hold it until the
    // transaction completes, then advance after a random gap.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : cmd_driver
        bit taken;
        taken = cmd_if.valid && cmd_if.ready;
        if (!rst_n)
        begin
            cmd_if.valid   <= 1'b0;
            cmd_if.payload <= '0;
            cmd_gap        <= 0;
        end
        else
        begin
            if (taken)
            begin
                predict_ring_results(cmd_if.payload);
                void'(cmd_backlog.pop_front());
            end
            // Hold a pending transaction; otherwise pick the next step.
            if (taken || !cmd_if.valid)
            begin
                if (cmd_gap != 0)
                begin
                    cmd_if.valid <= 1'b0;
                    cmd_gap      <= cmd_gap - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    cmd_if.valid   <= 1'b1;
                    cmd_if.payload <= cmd_backlog[0];
                    cmd_gap        <= pick_gap();
                end
                else
                begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each completed transaction with the oldest
    // prediction, and stall ready at random.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : res_monitor
        brb_pkg::res_item_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            res_stall    <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (ring_results_q.size() == 0)
                begin
                    $error("result transaction with nothing expected: status %0d data %0h",
                           res_if.payload.status, res_if.payload.data_byte);
                    fail_count++;
                end
                else
                begin
                    want = ring_results_q.pop_front();
                    check_field("status",     want.status,     res_if.payload.status);
                    check_field("data_byte",  want.data_byte,  res_if.payload.data_byte);
                    check_field("last",       want.last,       res_if.payload.last);
                    check_field("seq_first",  want.seq_first,  res_if.payload.seq_first);
                    check_field("seq_next",   want.seq_next,   res_if.payload.seq_next);
                    check_field("held_count", want.held_count, res_if.payload.held_count);
                end
            end
            if (res_stall != 0)
            begin
                res_if.ready <= 1'b0;
                res_stall    <= res_stall - 1;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    res_stall <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction completes for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int                        write_mix [6];
        logic [brb_pkg::SEQ_W-1:0] seq_load  [6];

        // Drive every input to a known value and hold reset.
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        seq_head  = '0;
        seq_tail  = '0;
        steady    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: start just below the wrap so seq_next rolls over.
        load_seq_base(32'hFFFF_FFFE);
        queue_command(brb_pkg::CMD_READ,  8'h00, 1);      // empty read
        queue_command(brb_pkg::CMD_PEEK,  8'h00, BURST);  // empty peek
        queue_command(brb_pkg::CMD_WRITE, 8'h00, 0);
        queue_command(brb_pkg::CMD_WRITE, 8'hFF, 127);
        queue_command(brb_pkg::CMD_WRITE, 8'h5A, 0);
        queue_command(brb_pkg::CMD_WRITE, 8'hA5, 0);
        queue_command(brb_pkg::CMD_PEEK,  8'h00, 0);      // zero-length with bytes held
        queue_command(brb_pkg::CMD_READ,  8'h00, 0);
        queue_command(brb_pkg::CMD_PEEK,  8'h00, 127);    // clipped to the bytes held
        queue_command(brb_pkg::CMD_PEEK,  8'h00, 1);
        queue_command(brb_pkg::CMD_READ,  8'h00, 1);
        queue_command(brb_pkg::CMD_READ,  8'h00, BURST);  // clipped to three bytes
        queue_command(brb_pkg::CMD_READ,  8'h00, 2);      // empty again
        queue_command(brb_pkg::CMD_WRITE, 8'h81, 0);
        queue_command(brb_pkg::CMD_WRITE, 8'h7E, 0);
        queue_command(brb_pkg::CMD_READ,  8'hFF, 127);
        queue_command(brb_pkg::CMD_PEEK,  8'h00, BURST + 1);

        // Back-to-back writes with no idling, peek the lot, then drain.
        load_seq_base(32'hFFFF_FFFF);
        steady = 1'b1;
        repeat (BURST_FILL - 3)
            queue_command(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'($urandom), 0);
        repeat (3)
            queue_command(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'($urandom),
                          $urandom_range(0, 127));
        queue_command(brb_pkg::CMD_PEEK, 8'h00, BURST);
        queue_command(brb_pkg::CMD_PEEK, 8'h00, 127);
        queue_command(brb_pkg::CMD_PEEK, 8'h00, 0);
        settle_ring();
        steady = 1'b0;
        for (int i = 0; i < 3; i++)
            queue_command(brb_pkg::CMD_READ, 8'h00, (i % 2 == 0) ? BURST : 127);

        // Random phases with different mixes and a fresh sequence base each.
        write_mix = '{60, 70, 45, 55, 35, 80};
        seq_load  = '{32'h0000_0000, $urandom, 32'h8000_0000, 32'h7FFF_FFFF,
                      $urandom, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 6; ph++)
        begin
            load_seq_base(seq_load[ph]);
            steady = (ph == 3);
            repeat (PHASE_ITEMS) cmd_backlog.push_back(random_command(write_mix[ph], 20));
        end

        // Close, then every command must report closed.
        load_seq_base($urandom);
        steady = 1'b0;
        repeat (3) queue_command(brb_pkg::CMD_WRITE, brb_pkg::BYTE_W'($urandom), 0);
        queue_command(brb_pkg::CMD_CLOSE, 8'h00, 0);
        queue_command(brb_pkg::CMD_WRITE, 8'hFF, 0);
        queue_command(brb_pkg::CMD_READ,  8'h00, 1);
        queue_command(brb_pkg::CMD_PEEK,  8'h00, BURST);
        queue_command(brb_pkg::CMD_CLOSE, 8'h00, 127);
        queue_command(brb_pkg::CMD_READ,  8'h00, 0);

        settle_ring();
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/brb_pkg.sv
rtl/brb_chan_if.sv
rtl/brb_ram.sv
rtl/byte_ring_buffer_with_sequence_unit.sv
sim/tb.sv
